// File: rtl/slec_pkg.sv
`default_nettype none

package slec_pkg;

   localparam int unsigned LBA_W        = 64;
   localparam int unsigned LEN_W        = 8;
   localparam int unsigned ADDR_W       = 32;
   localparam int unsigned SECTOR_BYTES = 512;
   localparam int unsigned RSP_DEPTH    = 4;

   localparam logic [ADDR_W-1:0] LOAD_BASE  = 32'h0000_7c00;
   localparam logic [ADDR_W-1:0] LOAD_RESET = LOAD_BASE + ADDR_W'(2 * SECTOR_BYTES);
   localparam logic [ADDR_W-1:0] SEG_MASK   = 32'hffff_0000;
   localparam logic [LEN_W-1:0]  RUN_LEN_MAX = 8'hff;

   typedef struct packed {
      logic [LBA_W-1:0] extent_lba;
      logic [LEN_W-1:0] extent_len;
      logic             final_extent;
   } slec_result_type;

   typedef struct packed {
      logic            valid0;
      slec_result_type result0;
      logic            valid1;
      slec_result_type result1;
   } slec_push_type;

endpackage

`default_nettype wire

// File: rtl/slec_if.sv
`default_nettype none

interface slec_req_if;
   import slec_pkg::*;
   logic             valid;
   logic             ready;
   logic [LBA_W-1:0] sector_lba;
   logic             last_sector;
   modport source (output valid, output sector_lba, output last_sector, input ready);
   modport sink (input valid, input sector_lba, input last_sector, output ready);
endinterface

interface slec_rsp_if;
   import slec_pkg::*;
   logic             valid;
   logic             ready;
   logic [LBA_W-1:0] extent_lba;
   logic [LEN_W-1:0] extent_len;
   logic             final_extent;
   modport source (output valid, output extent_lba, output extent_len, output final_extent,
                   input ready);
   modport sink (input valid, input extent_lba, input extent_len, input final_extent,
                 output ready);
endinterface

interface slec_csr_if;
   import slec_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/slec_rsp_fifo.sv
`default_nettype none

module slec_rsp_fifo #(
   parameter int unsigned DEPTH = slec_pkg::RSP_DEPTH
) (
   input  wire                      clock,
   input  wire                      reset,
   input  slec_pkg::slec_push_type  push,
   output logic                     room2,
   input  wire                      pop,
   output logic                     head_valid,
   output slec_pkg::slec_result_type head
);
   import slec_pkg::*;

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   slec_result_type   mem_ff [DEPTH];
   logic [IDX_W-1:0]  rd_ff, rd_in, wr_ff, wr_in, wr_next;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_next = bump(wr_ff);
      rd_in = pop ? bump(rd_ff) : rd_ff;
      if (push.valid1) begin
         wr_in = bump(wr_next);
      end else if (push.valid0) begin
         wr_in = wr_next;
      end else begin
         wr_in = wr_ff;
      end
      count_in = count_ff + CNT_W'(push.valid0) + CNT_W'(push.valid1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         count_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         mem_ff[wr_ff] <= push.result0;
      end
      if (push.valid1) begin
         mem_ff[wr_next] <= push.result1;
      end
   end

   assign room2 = (count_ff <= CNT_W'(DEPTH - 2));
   assign head_valid = (count_ff != '0);
   assign head = mem_ff[rd_ff];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue count exceeds its depth");
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.valid1 |-> push.valid0)
      else $error("second result pushed without a first");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid0 |-> room2)
      else $error("result pushed without room for two");
`endif

endmodule

`default_nettype wire

// File: rtl/sector_list_extent_coalescer.sv
// A result is written to the result queue when the item that closes its run is accepted.
// Throughput: one item per cycle while the queue has room for two results; the joining
// test, the 64-bit run-end add and the address step are all combinational between the
// state registers and the result queue. An item that yields two results pushes both at once.
// Reset is synchronous: no run is open, load_start and the next address read 0x8000.
`default_nettype none

module sector_list_extent_coalescer #(
   parameter int unsigned RSP_DEPTH = slec_pkg::RSP_DEPTH
) (
   input wire          clock,
   input wire          reset,
   slec_req_if.sink    req_chan,
   slec_rsp_if.source  rsp_chan,
   slec_csr_if.sink    csr_chan
);
   import slec_pkg::*;

   logic [ADDR_W-1:0] load_start_ff, load_start_in;
   logic [LBA_W-1:0]  run_start_ff, run_start_in;
   logic [LEN_W-1:0]  run_len_ff, run_len_in;
   logic [ADDR_W-1:0] run_base_ff, run_base_in;
   logic [ADDR_W-1:0] next_addr_ff, next_addr_in;

   logic              item_acc, csr_acc, room2, head_valid, joins, closing;
   logic [ADDR_W-1:0] cur_addr;
   logic [LBA_W-1:0]  run_end;
   slec_push_type     push;
   slec_result_type   head;

   assign item_acc = req_chan.valid && req_chan.ready;
   assign csr_acc = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = room2;

   always_comb begin
      cur_addr = (run_len_ff == '0) ? load_start_ff : next_addr_ff;
      run_end = run_start_ff + LBA_W'(run_len_ff);
      joins = (run_len_ff != '0) && (run_len_ff != RUN_LEN_MAX)
              && (req_chan.sector_lba == run_end)
              && (((cur_addr ^ run_base_ff) & SEG_MASK) == '0);
      closing = !joins && (run_len_ff != '0);

      load_start_in = csr_acc ? csr_chan.data : load_start_ff;
      run_start_in = run_start_ff;
      run_len_in = run_len_ff;
      run_base_in = run_base_ff;
      next_addr_in = next_addr_ff;
      push = '0;

      if (item_acc) begin
         if (joins) begin
            run_len_in = run_len_ff + 1'b1;
         end else begin
            run_start_in = req_chan.sector_lba;
            run_len_in = LEN_W'(1);
            run_base_in = cur_addr;
         end
         next_addr_in = cur_addr + ADDR_W'(SECTOR_BYTES);

         if (closing) begin
            push.valid0 = 1'b1;
            push.result0 = '{extent_lba: run_start_ff, extent_len: run_len_ff,
                             final_extent: 1'b0};
            push.valid1 = req_chan.last_sector;
            push.result1 = '{extent_lba: run_start_in, extent_len: run_len_in,
                             final_extent: 1'b1};
         end else begin
            push.valid0 = req_chan.last_sector;
            push.result0 = '{extent_lba: run_start_in, extent_len: run_len_in,
                             final_extent: 1'b1};
         end

         if (req_chan.last_sector) begin
            run_start_in = '0;
            run_len_in = '0;
            run_base_in = '0;
            next_addr_in = load_start_ff;
         end
      end else if (csr_acc && (run_len_ff == '0)) begin
         next_addr_in = csr_chan.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_start_ff <= LOAD_RESET;
         run_start_ff <= '0;
         run_len_ff <= '0;
         run_base_ff <= '0;
         next_addr_ff <= LOAD_RESET;
      end else begin
         load_start_ff <= load_start_in;
         run_start_ff <= run_start_in;
         run_len_ff <= run_len_in;
         run_base_ff <= run_base_in;
         next_addr_ff <= next_addr_in;
      end
   end

   slec_rsp_fifo #(
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .room2(room2),
      .pop(rsp_chan.valid && rsp_chan.ready),
      .head_valid(head_valid),
      .head(head)
   );

   assign rsp_chan.valid = head_valid;
   assign rsp_chan.extent_lba = head.extent_lba;
   assign rsp_chan.extent_len = head.extent_len;
   assign rsp_chan.final_extent = head.final_extent;

`ifndef SYNTHESIS
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      item_acc && req_chan.last_sector |=> run_len_ff == '0)
      else $error("run still open after the last item of a list");
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      item_acc && req_chan.last_sector |=> rsp_chan.valid)
      else $error("no result offered after the last item of a list");
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      run_len_ff == '0 |-> run_start_ff == '0 && run_base_ff == '0)
      else $error("run state not cleared while no run is open");
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.extent_len != '0)
      else $error("extent offered with zero length");
`endif

endmodule

`default_nettype wire
